@@ hw/rtl/gts_pkg.sv @@
// Shared types, constants and the tap weight lookup of the trajectory smoother.
package gts_pkg;

   localparam int ID_W        = 31;
   localparam int HEIGHT_W    = 32;
   localparam int RADIUS_W    = 3;
   localparam int NEAR_W      = 64;
   localparam int FAR_W       = 48;
   localparam int WEIGHT_W    = 16;
   localparam int WSUM_W      = 20;
   localparam int IDX_W_MAX   = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd3;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 3'd2;
   localparam logic [WEIGHT_W-1:0] CENTRE_WEIGHT = 16'h8000;

   typedef struct packed {
      logic                 shift;
      logic                 acc_clear;
      logic                 tap_en;
      logic [IDX_W_MAX-1:0] tap_idx;
      logic [IDX_W_MAX-1:0] center_idx;
      logic                 div_start;
      logic                 rsp_load;
      logic                 rsp_last;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic [WEIGHT_W-1:0] tap_weight(
      input logic [IDX_W_MAX-1:0] tap_off,
      input logic [NEAR_W-1:0]    near,
      input logic [FAR_W-1:0]     far
   );
      logic [WEIGHT_W-1:0] w;
      unique case (tap_off)
         5'd0: w = CENTRE_WEIGHT;
         5'd1: w = near[15:0];
         5'd2: w = near[31:16];
         5'd3: w = near[47:32];
         5'd4: w = near[63:48];
         5'd5: w = far[15:0];
         5'd6: w = far[31:16];
         5'd7: w = far[47:32];
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/gts_ctrl.sv @@
// Sequencer: window counts, per-result tap loop and divider/response handshake.
module gts_ctrl #(
   parameter int MAX_RADIUS = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_final_pose,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [gts_pkg::RADIUS_W-1:0]    radius,
   output gts_pkg::cmd_type                cmd,
   input  gts_pkg::status_type             status
);

   localparam int DEPTH = 2 * MAX_RADIUS + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MAC   = 3'd2;
   localparam logic [2:0] ST_TAIL  = 3'd3;
   localparam logic [2:0] ST_DIVS  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] rec_ff, rec_in, emit_ff, emit_in, r_ff, r_in;
   logic             final_ff, final_in;
   logic [IDX_W-1:0] s_ff, s_in, c_ff, c_in, hi_ff, hi_in;

   logic [CNT_W-1:0] pending;
   logic [CNT_W:0]   c_w, hi_w, lim_w, lo_w, r_w;
   logic             run;

   assign pending = rec_ff - emit_ff;
   assign r_w     = (CNT_W+1)'(r_ff);
   assign c_w     = (CNT_W+1)'(pending) - 1'b1;
   assign hi_w    = c_w + r_w;
   assign lim_w   = (CNT_W+1)'(rec_ff) - 1'b1;
   assign lo_w    = (c_w >= r_w) ? c_w - r_w : '0;
   assign run     = (rec_ff > emit_ff) && (final_ff || (pending > r_ff));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      rec_in   = rec_ff;
      emit_in  = emit_ff;
      r_in     = r_ff;
      final_in = final_ff;
      s_in     = s_ff;
      c_in     = c_ff;
      hi_in    = hi_ff;
      cmd            = '0;
      cmd.tap_idx    = gts_pkg::IDX_W_MAX'(s_ff);
      cmd.center_idx = gts_pkg::IDX_W_MAX'(c_ff);
      cmd.rsp_last   = final_ff && (c_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.shift = 1'b1;
               final_in  = req_final_pose;
               r_in      = (int'(radius) > MAX_RADIUS) ? CNT_W'(MAX_RADIUS) : CNT_W'(radius);
               if (rec_ff >= CNT_W'(DEPTH)) begin
                  rec_in  = CNT_W'(DEPTH);
                  emit_in = (emit_ff != '0) ? emit_ff - 1'b1 : emit_ff;
               end else begin
                  rec_in = rec_ff + 1'b1;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (run) begin
               cmd.acc_clear = 1'b1;
               c_in     = IDX_W'(c_w);
               s_in     = IDX_W'(lo_w);
               hi_in    = IDX_W'((hi_w > lim_w) ? lim_w : hi_w);
               state_in = ST_MAC;
            end else begin
               if (final_ff) begin
                  rec_in  = '0;
                  emit_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MAC: begin
            cmd.tap_en = 1'b1;
            if (s_ff == hi_ff) begin
               state_in = ST_TAIL;
            end else begin
               s_in = s_ff + 1'b1;
            end
         end
         ST_TAIL: state_in = ST_DIVS;
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               emit_in  = emit_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rec_ff   <= '0;
         emit_ff  <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rec_ff   <= rec_in;
         emit_ff  <= emit_in;
         final_ff <= final_in;
      end
      r_ff  <= r_in;
      s_ff  <= s_in;
      c_ff  <= c_in;
      hi_ff <= hi_in;
   end

endmodule

@@ hw/rtl/gts_datapath.sv @@
// Window shift line, weighted accumulators, bit-serial dividers and result register.
module gts_datapath #(
   parameter int MAX_RADIUS = 7,
   parameter int POS_WIDTH  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gts_pkg::cmd_type                      cmd,
   output gts_pkg::status_type                   status,
   input  logic [gts_pkg::ID_W-1:0]              req_image_number,
   input  logic signed [POS_WIDTH-1:0]           req_pos_x,
   input  logic signed [POS_WIDTH-1:0]           req_pos_y,
   input  logic [gts_pkg::NEAR_W-1:0]            weights_near,
   input  logic [gts_pkg::FAR_W-1:0]             weights_far,
   input  logic signed [gts_pkg::HEIGHT_W-1:0]   plane_height,
   output logic [gts_pkg::ID_W-1:0]              rsp_out_image_number,
   output logic signed [POS_WIDTH-1:0]           rsp_smooth_x,
   output logic signed [POS_WIDTH-1:0]           rsp_smooth_y,
   output logic signed [gts_pkg::HEIGHT_W-1:0]   rsp_smooth_z,
   output logic                                  rsp_end_of_run
);

   localparam int DEPTH  = 2 * MAX_RADIUS + 1;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int PROD_W = POS_WIDTH + gts_pkg::WEIGHT_W + 1;
   localparam int ACC_W  = POS_WIDTH + gts_pkg::WSUM_W + 1;
   localparam int DCNT_W = $clog2(ACC_W + 1);
   localparam int WS_W   = gts_pkg::WSUM_W;

   logic signed [POS_WIDTH-1:0]    x_ff [DEPTH];
   logic signed [POS_WIDTH-1:0]    y_ff [DEPTH];
   logic [gts_pkg::ID_W-1:0]       id_ff [DEPTH];

   logic [IDX_W-1:0]               tap, ctr, tap_off;
   logic [gts_pkg::WEIGHT_W-1:0]   w;
   logic signed [PROD_W-1:0]       prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   logic                           prod_vld_ff;
   logic signed [ACC_W-1:0]        acc_x_ff, acc_y_ff;
   logic [WS_W-1:0]                wsum_ff;
   logic [gts_pkg::ID_W-1:0]       cen_id_ff;

   logic signed [ACC_W-1:0]        num_x, num_y;
   logic [ACC_W-1:0]               dvd_x_ff, dvd_y_ff;
   logic [WS_W-1:0]                rem_x_ff, rem_y_ff;
   logic                           neg_x_ff, neg_y_ff;
   logic [DCNT_W-1:0]              dcnt_ff;
   logic [WS_W:0]                  trial_x, trial_y;
   logic                           qb_x, qb_y;
   logic [ACC_W-1:0]               res_x, res_y;

   assign tap     = cmd.tap_idx[IDX_W-1:0];
   assign ctr     = cmd.center_idx[IDX_W-1:0];
   assign tap_off = (tap > ctr) ? tap - ctr : ctr - tap;
   assign w       = gts_pkg::tap_weight(gts_pkg::IDX_W_MAX'(tap_off), weights_near, weights_far);

   assign prod_x_in = PROD_W'(x_ff[tap]) * $signed(PROD_W'({1'b0, w}));
   assign prod_y_in = PROD_W'(y_ff[tap]) * $signed(PROD_W'({1'b0, w}));

   assign num_x = acc_x_ff + $signed(ACC_W'(wsum_ff >> 1));
   assign num_y = acc_y_ff + $signed(ACC_W'(wsum_ff >> 1));

   assign trial_x = {rem_x_ff, dvd_x_ff[ACC_W-1]};
   assign trial_y = {rem_y_ff, dvd_y_ff[ACC_W-1]};
   assign qb_x    = (trial_x >= {1'b0, wsum_ff});
   assign qb_y    = (trial_y >= {1'b0, wsum_ff});

   assign res_x = neg_x_ff ? ((rem_x_ff != '0) ? ~dvd_x_ff : -dvd_x_ff) : dvd_x_ff;
   assign res_y = neg_y_ff ? ((rem_y_ff != '0) ? ~dvd_y_ff : -dvd_y_ff) : dvd_y_ff;

   assign status.div_done = (dcnt_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         x_ff[0]  <= req_pos_x;
         y_ff[0]  <= req_pos_y;
         id_ff[0] <= req_image_number;
         for (int i = 1; i < DEPTH; i++) begin
            x_ff[i]  <= x_ff[i-1];
            y_ff[i]  <= y_ff[i-1];
            id_ff[i] <= id_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         dcnt_ff     <= '0;
      end else begin
         prod_vld_ff <= cmd.tap_en;
         if (cmd.div_start) begin
            dcnt_ff <= DCNT_W'(ACC_W);
         end else if (dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - 1'b1;
         end
      end
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      if (cmd.acc_clear) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         wsum_ff  <= '0;
      end else begin
         if (prod_vld_ff) begin
            acc_x_ff <= acc_x_ff + ACC_W'(prod_x_ff);
            acc_y_ff <= acc_y_ff + ACC_W'(prod_y_ff);
         end
         if (cmd.tap_en) begin
            wsum_ff <= wsum_ff + WS_W'(w);
         end
      end
      if (cmd.tap_en && (tap == ctr)) begin
         cen_id_ff <= id_ff[tap];
      end
      if (cmd.div_start) begin
         neg_x_ff <= num_x[ACC_W-1];
         neg_y_ff <= num_y[ACC_W-1];
         dvd_x_ff <= num_x[ACC_W-1] ? ACC_W'(-num_x) : ACC_W'(num_x);
         dvd_y_ff <= num_y[ACC_W-1] ? ACC_W'(-num_y) : ACC_W'(num_y);
         rem_x_ff <= '0;
         rem_y_ff <= '0;
      end else if (dcnt_ff != '0) begin
         dvd_x_ff <= {dvd_x_ff[ACC_W-2:0], qb_x};
         dvd_y_ff <= {dvd_y_ff[ACC_W-2:0], qb_y};
         rem_x_ff <= qb_x ? WS_W'(trial_x - {1'b0, wsum_ff}) : WS_W'(trial_x);
         rem_y_ff <= qb_y ? WS_W'(trial_y - {1'b0, wsum_ff}) : WS_W'(trial_y);
      end
      if (cmd.rsp_load) begin
         rsp_out_image_number <= cen_id_ff;
         rsp_smooth_x         <= res_x[POS_WIDTH-1:0];
         rsp_smooth_y         <= res_y[POS_WIDTH-1:0];
         rsp_smooth_z         <= plane_height;
         rsp_end_of_run       <= cmd.rsp_last;
      end
   end

endmodule

@@ hw/rtl/gaussian_trajectory_smoother_top.sv @@
// Gaussian trajectory smoother: top level with configuration registers.
// Smooths x and y of a stream of camera positions with a symmetric weighted
// window, renormalized at the run edges, one item at a time. For each result
// that an accepted item releases, the w taps of its window (w up to
// 2*radius+1) go one at a time through the multiply-accumulate path, then
// bit-serial dividers for x and y run one quotient bit per cycle. With no
// result the block passes through its check state back to idle and is ready
// again.
// Results lag the input by radius items; the final pose flushes all of them.
module gaussian_trajectory_smoother_top #(
   parameter int MAX_RADIUS = 7,
   parameter int POS_WIDTH  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [gts_pkg::ID_W-1:0]              req_image_number,
   input  logic signed [POS_WIDTH-1:0]           req_pos_x,
   input  logic signed [POS_WIDTH-1:0]           req_pos_y,
   input  logic                                  req_final_pose,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [gts_pkg::ID_W-1:0]              rsp_out_image_number,
   output logic signed [POS_WIDTH-1:0]           rsp_smooth_x,
   output logic signed [POS_WIDTH-1:0]           rsp_smooth_y,
   output logic signed [gts_pkg::HEIGHT_W-1:0]   rsp_smooth_z,
   output logic                                  rsp_end_of_run,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gts_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gts_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   logic [gts_pkg::RADIUS_W-1:0]        radius_ff;
   logic [gts_pkg::NEAR_W-1:0]          near_ff;
   logic [gts_pkg::FAR_W-1:0]           far_ff;
   logic signed [gts_pkg::HEIGHT_W-1:0] height_ff;
   gts_pkg::cmd_type                    cmd;
   gts_pkg::status_type                 status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= gts_pkg::RADIUS_RESET;
         near_ff   <= '0;
         far_ff    <= '0;
         height_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            gts_pkg::CSR_RADIUS: radius_ff <= csr_wdata[gts_pkg::RADIUS_W-1:0];
            gts_pkg::CSR_NEAR:   near_ff   <= csr_wdata[gts_pkg::NEAR_W-1:0];
            gts_pkg::CSR_FAR:    far_ff    <= csr_wdata[gts_pkg::FAR_W-1:0];
            gts_pkg::CSR_HEIGHT: height_ff <= csr_wdata[gts_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   gts_ctrl #(.MAX_RADIUS(MAX_RADIUS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_final_pose (req_final_pose),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .radius         (radius_ff),
      .cmd            (cmd),
      .status         (status)
   );

   gts_datapath #(.MAX_RADIUS(MAX_RADIUS), .POS_WIDTH(POS_WIDTH)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_image_number     (req_image_number),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .weights_near         (near_ff),
      .weights_far          (far_ff),
      .plane_height         (height_ff),
      .rsp_out_image_number (rsp_out_image_number),
      .rsp_smooth_x         (rsp_smooth_x),
      .rsp_smooth_y         (rsp_smooth_y),
      .rsp_smooth_z         (rsp_smooth_z),
      .rsp_end_of_run       (rsp_end_of_run)
   );

   a_no_accept_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("item accepted while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("controller did not start work on accepted item");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.shift, cmd.acc_clear, cmd.tap_en, cmd.div_start, cmd.rsp_load}))
      else $error("conflicting datapath commands");

endmodule
